>>> rtl/core/bmcw_pkg.sv
package bmcw_pkg;

	localparam int MAP_DEPTH_DEF   = 4096;
	localparam int BLOCK_BYTES_DEF = 1024;
	localparam int SECTOR_BYTES    = 512;

	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int LINK_W   = 12;
	localparam int ROW_W    = 2 * LINK_W;
	localparam int DIR_W    = 16;
	localparam int CNT_W    = 13;
	localparam int OFFSET_W = 26;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// content starts after four sectors plus the directory sectors
	localparam int BASE_SECTORS = 4;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DIR_BLOCKS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENTRIES = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_LINK
	} walk_state_t;

endpackage

>>> rtl/core/bmcw_ifs.sv
interface bmcw_req_if;
	logic                          valid;
	logic                          ready;
	logic [bmcw_pkg::OP_W-1:0]     op;
	logic [bmcw_pkg::BYTE_W-1:0]   map_byte;
	logic [bmcw_pkg::LINK_W-1:0]   start_block;

	modport source(output valid, op, map_byte, start_block, input ready);
	modport sink(input valid, op, map_byte, start_block, output ready);
endinterface

interface bmcw_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [bmcw_pkg::LINK_W-1:0]     block_number;
	logic [bmcw_pkg::OFFSET_W-1:0]   byte_offset;
	logic                            is_last;
	logic                            status;

	modport source(output valid, block_number, byte_offset, is_last, status, input ready);
	modport sink(input valid, block_number, byte_offset, is_last, status, output ready);
endinterface

interface bmcw_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bmcw_pkg::CFG_IDX_W-1:0]    index;
	logic [bmcw_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/block_map_chain_walker.sv
// channel | dir | handshake     | word
// req     | in  | valid/ready   | op, map_byte, start_block
// rsp     | out | valid/ready   | block_number, byte_offset, is_last, status
// cfg     | in  | valid/ready   | index, data (0 dir_blocks, 1 map_entries)
// Load and start words complete when accepted; a step also passes through the link state,
// since the link memory read is registered before the next link is known.
// Output register holds a finished result while the next word is accepted;
// a step whose result slot is still full waits in the link state.
// Reset clears control and config; link memory has no clearing pass.
module block_map_chain_walker #(
	parameter int MAP_DEPTH   = bmcw_pkg::MAP_DEPTH_DEF,
	parameter int BLOCK_BYTES = bmcw_pkg::BLOCK_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bmcw_req_if.sink     req,
	bmcw_rsp_if.source   rsp,
	bmcw_cfg_if.sink     cfg
);

	localparam int ROWS = (MAP_DEPTH + 1) / 2;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW   = bmcw_pkg::CNT_W;

	logic [bmcw_pkg::DIR_W-1:0]  dir_blocks_q;
	logic [CW-1:0]               map_entries_q;
	logic [CW-1:0]               lim;
	logic                        acc;
	logic                        busy;
	logic                        wr_en;
	logic [RAW-1:0]              wr_row;
	logic [bmcw_pkg::ROW_W-1:0]  wr_data;
	logic                        rd_en;
	logic [RAW-1:0]              rd_row;
	logic [bmcw_pkg::ROW_W-1:0]  rd_data;

	assign cfg.ready = 1'b1;
	assign req.ready = !busy;
	assign acc       = req.valid && req.ready;
	assign lim       = (map_entries_q > CW'(MAP_DEPTH)) ? CW'(MAP_DEPTH) : map_entries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_blocks_q  <= '0;
			map_entries_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bmcw_pkg::CFG_DIR_BLOCKS:  dir_blocks_q  <= cfg.data;
				bmcw_pkg::CFG_MAP_ENTRIES: map_entries_q <= cfg.data[CW-1:0];
			endcase
		end
	end

	bmcw_loader #(.MAP_DEPTH(MAP_DEPTH)) u_loader (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_go  (acc && (req.op == bmcw_pkg::OP_LOAD)),
		.map_byte (req.map_byte),
		.lim      (lim),
		.wr_en    (wr_en),
		.wr_row   (wr_row),
		.wr_data  (wr_data)
	);

	bmcw_link_mem #(.MAP_DEPTH(MAP_DEPTH)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_row  (wr_row),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	bmcw_walker #(
		.MAP_DEPTH   (MAP_DEPTH),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_go    (acc && (req.op == bmcw_pkg::OP_START)),
		.step_go     (acc && (req.op == bmcw_pkg::OP_STEP)),
		.start_block (req.start_block),
		.lim         (lim),
		.dir_blocks  (dir_blocks_q),
		.rd_data     (rd_data),
		.rd_en       (rd_en),
		.rd_row      (rd_row),
		.busy        (busy),
		.rsp         (rsp)
	);

endmodule

>>> rtl/core/bmcw_link_mem.sv
module bmcw_link_mem #(
	parameter  int MAP_DEPTH = bmcw_pkg::MAP_DEPTH_DEF,
	localparam int ROWS      = (MAP_DEPTH + 1) / 2,
	localparam int RAW       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [RAW-1:0]                wr_row,
	input  logic [bmcw_pkg::ROW_W-1:0]    wr_data,
	input  logic                          rd_en,
	input  logic [RAW-1:0]                rd_row,
	output logic [bmcw_pkg::ROW_W-1:0]    rd_data
);

	// two links per row, even entry in the high half
	logic [bmcw_pkg::ROW_W-1:0] mem [ROWS];
	logic [bmcw_pkg::ROW_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/core/bmcw_loader.sv
module bmcw_loader #(
	parameter  int MAP_DEPTH = bmcw_pkg::MAP_DEPTH_DEF,
	localparam int ROWS      = (MAP_DEPTH + 1) / 2,
	localparam int RAW       = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_go,
	input  logic [bmcw_pkg::BYTE_W-1:0]   map_byte,
	input  logic [bmcw_pkg::CNT_W-1:0]    lim,
	output logic                          wr_en,
	output logic [RAW-1:0]                wr_row,
	output logic [bmcw_pkg::ROW_W-1:0]    wr_data
);

	logic [1:0]                      phase_q;
	logic [2*bmcw_pkg::BYTE_W-1:0]   accum_q;
	logic [bmcw_pkg::CNT_W-1:0]      fill_q;
	logic                            take;

	assign take    = load_go && (fill_q < lim);
	assign wr_en   = take && (phase_q == 2'd2);
	assign wr_row  = fill_q[RAW:1];
	assign wr_data = {accum_q, map_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			accum_q <= '0;
			fill_q  <= '0;
		end else if (take) begin
			if (phase_q == 2'd2) begin
				phase_q <= '0;
				accum_q <= '0;
				fill_q  <= fill_q + bmcw_pkg::CNT_W'(2);
			end else begin
				phase_q <= phase_q + 2'd1;
				accum_q <= {accum_q[bmcw_pkg::BYTE_W-1:0], map_byte};
			end
		end
	end

endmodule

>>> rtl/core/bmcw_walker.sv
module bmcw_walker #(
	parameter  int MAP_DEPTH   = bmcw_pkg::MAP_DEPTH_DEF,
	parameter  int BLOCK_BYTES = bmcw_pkg::BLOCK_BYTES_DEF,
	localparam int ROWS        = (MAP_DEPTH + 1) / 2,
	localparam int RAW         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start_go,
	input  logic                          step_go,
	input  logic [bmcw_pkg::LINK_W-1:0]   start_block,
	input  logic [bmcw_pkg::CNT_W-1:0]    lim,
	input  logic [bmcw_pkg::DIR_W-1:0]    dir_blocks,
	input  logic [bmcw_pkg::ROW_W-1:0]    rd_data,
	output logic                          rd_en,
	output logic [RAW-1:0]                rd_row,
	output logic                          busy,
	bmcw_rsp_if.source                    rsp
);

	localparam int LW   = bmcw_pkg::LINK_W;
	localparam int OW   = bmcw_pkg::OFFSET_W;
	localparam int SECT_SH = $clog2(bmcw_pkg::SECTOR_BYTES);

	bmcw_pkg::walk_state_t state_q, state_d;

	logic [LW-1:0]   cur_q;
	logic            active_q;
	logic [LW-1:0]   blk_s1;
	logic            oob_s1;
	logic            odd_s1;
	logic            out_valid_q;
	logic [LW-1:0]   out_blk_q;
	logic [OW-1:0]   out_off_q;
	logic            out_last_q;
	logic            out_status_q;

	logic [LW-1:0]   idx;
	logic            oob;
	logic            walk;
	logic            out_free;
	logic            finish;
	logic [LW-1:0]   link;
	logic            last;
	logic [LW-1:0]   blk_m2;
	logic [OW-1:0]   base;
	logic [OW-1:0]   offset;

	assign idx      = cur_q - LW'(2);
	assign oob      = {1'b0, idx} >= lim;
	assign walk     = step_go && active_q;
	assign out_free = !out_valid_q || rsp.ready;
	assign rd_row   = idx[RAW:1];

	assign link   = odd_s1 ? rd_data[LW-1:0] : rd_data[2*LW-1:LW];
	assign last   = oob_s1 || (link <= LW'(1));
	assign blk_m2 = blk_s1 - LW'(2);
	assign base   = (OW'(dir_blocks) + OW'(bmcw_pkg::BASE_SECTORS)) << SECT_SH;
	assign offset = base + OW'(blk_m2) * OW'(BLOCK_BYTES);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmcw_pkg::ST_IDLE: begin
				if (walk) begin
					state_d = bmcw_pkg::ST_LINK;
				end
			end
			bmcw_pkg::ST_LINK: begin
				if (out_free) begin
					state_d = bmcw_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		rd_en  = 1'b0;
		busy   = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			bmcw_pkg::ST_IDLE: begin
				rd_en = walk && !oob;
			end
			bmcw_pkg::ST_LINK: begin
				busy   = 1'b1;
				finish = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmcw_pkg::ST_IDLE;
			cur_q       <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_go) begin
				cur_q    <= start_block;
				active_q <= start_block >= LW'(2);
			end else if (finish) begin
				if (!oob_s1) begin
					cur_q <= link;
				end
				active_q <= !last;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walk) begin
			blk_s1 <= cur_q;
			oob_s1 <= oob;
			odd_s1 <= idx[0];
		end
		if (finish) begin
			out_blk_q    <= blk_s1;
			out_off_q    <= offset;
			out_last_q   <= last;
			out_status_q <= oob_s1;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.block_number = out_blk_q;
	assign rsp.byte_offset  = out_off_q;
	assign rsp.is_last      = out_last_q;
	assign rsp.status       = out_status_q;

	a_read_then_link: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> state_q == bmcw_pkg::ST_LINK)
		else $error("link read without link state");

	a_link_needs_chain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmcw_pkg::ST_LINK |-> active_q)
		else $error("link pending on inactive chain");

	a_no_step_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go || start_go) |-> state_q == bmcw_pkg::ST_IDLE)
		else $error("word accepted during link fetch");

	a_error_ends_chain: assert property (@(posedge clk) disable iff (!arst_n)
		finish && oob_s1 |=> !active_q && out_valid_q && rsp.is_last)
		else $error("out-of-map link did not end chain");

endmodule

>>> verif/block_map_chain_walker_tb.sv
module block_map_chain_walker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bmcw_pkg::*;

	localparam logic [OP_W-1:0] OP_IDLE = 2'd3;
	localparam int SHADOW = 0;
	localparam int LIVE = 1;
	localparam int FIRST_BLOCK = 2;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	// packed map bytes for the directed part: links 3,5 / FFF,1 / 0,8 / 7,ABC
	localparam logic [95:0] SAMPLE_MAP = 96'h003005_FFF001_000008_007ABC;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] map_byte;
		logic [LINK_W-1:0] start_block;
	} map_word_t;

	typedef struct packed {
		logic [LINK_W-1:0]   block_number;
		logic [OFFSET_W-1:0] byte_offset;
		logic                is_last;
		logic                status;
	} hop_t;

	logic clk = 1'b0;
	logic arst_n;

	bmcw_req_if req();
	bmcw_rsp_if rsp();
	bmcw_cfg_if cfg();

	block_map_chain_walker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// two copies of the map state: SHADOW steers stimulus, LIVE predicts results
	logic [LINK_W-1:0]   map_link   [2][MAP_DEPTH_DEF];
	bit                  map_set    [2][MAP_DEPTH_DEF];
	logic [1:0]          pack_phase [2];
	logic [2*BYTE_W-1:0] pack_accum [2];
	logic [CNT_W-1:0]    fill_ptr   [2];
	logic [LINK_W-1:0]   walk_block [2];
	bit                  walk_on    [2];
	logic [DIR_W-1:0]    dir_len    [2];
	logic [CNT_W-1:0]    map_count  [2];

	map_word_t word_backlog[$];
	hop_t      hop_expect[$];

	bit req_busy;
	bit req_taken;
	bit req_calm;
	int req_gap;
	bit rsp_taken;
	bit rsp_calm;
	int rsp_stall;
	bit hold_req;
	int hold_left;
	int idle_cycles;
	int errors;
	int words_taken;
	int hops_seen;
	int chain_ends;
	int map_exits;

	map_word_t mon_word;
	hop_t      mon_hop;
	bit        mon_emit;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	function automatic int unsigned map_limit(input int s);
		return (map_count[s] > MAP_DEPTH_DEF) ? MAP_DEPTH_DEF : map_count[s];
	endfunction

	function automatic bit step_ok(input int s);
		int unsigned idx;
		idx = walk_block[s] - FIRST_BLOCK;
		return !walk_on[s] || idx >= map_limit(s) || map_set[s][idx];
	endfunction

	function automatic bit start_ok(input logic [LINK_W-1:0] blk);
		int unsigned idx;
		idx = blk - FIRST_BLOCK;
		return blk < FIRST_BLOCK || idx >= map_limit(SHADOW) || map_set[SHADOW][idx];
	endfunction

	function automatic logic [LINK_W-1:0] pick_start();
		logic [LINK_W-1:0] blk;
		int unsigned v;
		for (int t = 0; t < 8; t++) begin
			if (fill_ptr[SHADOW] > 0 && $urandom_range(0, 3) != 0) begin
				v = FIRST_BLOCK + $urandom_range(0, fill_ptr[SHADOW] - 1);
				blk = (v > 4095) ? 12'hFFF : LINK_W'(v);
			end else begin
				blk = LINK_W'($urandom);
			end
			if (start_ok(blk))
				return blk;
		end
		return '0;
	endfunction

	function automatic logic [LINK_W-1:0] pick_link();
		int unsigned r;
		int unsigned v;
		r = $urandom_range(0, 99);
		if (r < 10)
			return LINK_W'($urandom_range(0, 1));
		if (r < 20)
			return LINK_W'($urandom);
		v = FIRST_BLOCK + $urandom_range(0, fill_ptr[SHADOW] + 3);
		return (v > 4095) ? 12'hFFF : LINK_W'(v);
	endfunction

	task automatic reset_ctx(input int s);
		for (int i = 0; i < MAP_DEPTH_DEF; i++) begin
			map_link[s][i] = '0;
			map_set[s][i] = 1'b0;
		end
		pack_phase[s] = '0;
		pack_accum[s] = '0;
		fill_ptr[s] = '0;
		walk_block[s] = '0;
		walk_on[s] = 1'b0;
		dir_len[s] = '0;
		map_count[s] = '0;
	endtask

	task automatic walk_word(input int s, input map_word_t w, output bit emit, output hop_t hop);
		int unsigned lim;
		int unsigned idx;
		logic [ROW_W-1:0] row;
		logic [LINK_W-1:0] nxt;
		emit = 1'b0;
		hop = '0;
		lim = map_limit(s);
		case (w.op)
			OP_LOAD: begin
				if (fill_ptr[s] < lim) begin
					if (pack_phase[s] < 2) begin
						pack_accum[s] = {pack_accum[s][BYTE_W-1:0], w.map_byte};
						pack_phase[s] = pack_phase[s] + 1;
					end else begin
						row = {pack_accum[s], w.map_byte};
						map_link[s][fill_ptr[s]] = row[ROW_W-1:LINK_W];
						map_set[s][fill_ptr[s]] = 1'b1;
						// odd tail entry past the limit is dropped
						if (fill_ptr[s] + 1 < lim) begin
							map_link[s][fill_ptr[s] + 1] = row[LINK_W-1:0];
							map_set[s][fill_ptr[s] + 1] = 1'b1;
						end
						fill_ptr[s] = fill_ptr[s] + 2;
						pack_phase[s] = '0;
						pack_accum[s] = '0;
					end
				end
			end
			OP_START: begin
				walk_block[s] = w.start_block;
				walk_on[s] = w.start_block >= FIRST_BLOCK;
			end
			OP_STEP: begin
				if (walk_on[s]) begin
					idx = walk_block[s] - FIRST_BLOCK;
					emit = 1'b1;
					hop.block_number = walk_block[s];
					hop.byte_offset = OFFSET_W'(BASE_SECTORS * SECTOR_BYTES
						+ SECTOR_BYTES * dir_len[s] + idx * BLOCK_BYTES_DEF);
					if (idx >= lim) begin
						hop.is_last = 1'b1;
						hop.status = 1'b1;
						walk_on[s] = 1'b0;
					end else begin
						nxt = map_link[s][idx];
						hop.is_last = nxt < FIRST_BLOCK;
						walk_block[s] = nxt;
						walk_on[s] = nxt >= FIRST_BLOCK;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
			input logic [LINK_W-1:0] blk);
		map_word_t w;
		hop_t unused_hop;
		bit unused_emit;
		w.op = op;
		w.map_byte = b;
		w.start_block = blk;
		walk_word(SHADOW, w, unused_emit, unused_hop);
		word_backlog.push_back(w);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg.index <= idx;
		cfg.data <= CFG_DATA_W'(val);
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		for (int s = 0; s < 2; s++) begin
			if (idx == CFG_DIR_BLOCKS)
				dir_len[s] = val[DIR_W-1:0];
			else
				map_count[s] = val[CNT_W-1:0];
		end
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (word_backlog.size() != 0 || req_busy || hop_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned dir, input int unsigned entries,
			input int unsigned budget, input bit pressure);
		int unsigned planned;
		int unsigned pick;
		int unsigned len;
		logic [ROW_W-1:0] row;
		logic [OP_W-1:0] op;
		write_reg(CFG_DIR_BLOCKS, dir);
		write_reg(CFG_MAP_ENTRIES, entries);
		planned = 0;
		while (planned < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 30 && fill_ptr[SHADOW] < map_limit(SHADOW)) begin
				row = {pick_link(), pick_link()};
				push_word(OP_LOAD, row[23:16], LINK_W'($urandom));
				push_word(OP_LOAD, row[15:8], LINK_W'($urandom));
				push_word(OP_LOAD, row[7:0], LINK_W'($urandom));
				planned += 3;
			end else if (pick < 85) begin
				push_word(OP_START, BYTE_W'($urandom), pick_start());
				planned++;
				len = $urandom_range(1, 24);
				while (len > 0 && walk_on[SHADOW] && step_ok(SHADOW)) begin
					push_word(OP_STEP, BYTE_W'($urandom), LINK_W'($urandom));
					planned++;
					len--;
				end
			end else begin
				op = OP_W'($urandom_range(0, 3));
				if (op == OP_STEP && !step_ok(SHADOW))
					push_word(OP_START, BYTE_W'($urandom), pick_start());
				else
					push_word(op, BYTE_W'($urandom), LINK_W'($urandom));
				planned++;
			end
		end
		if (pressure)
			hold_req = 1'b1;
		settle();
	endtask

	// sender
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= OP_IDLE;
			req.map_byte <= '0;
			req.start_block <= '0;
			req_busy = 1'b0;
			req_taken = 1'b0;
			req_gap = 0;
		end else begin
			if (req_taken) begin
				req_taken = 1'b0;
				req_busy = 1'b0;
				if ($urandom_range(0, 63) == 0)
					req_calm = !req_calm;
				req_gap = req_calm ? 0 : $urandom_range(0, 3);
			end
			if (!req_busy && word_backlog.size() != 0) begin
				if (req_gap > 0) begin
					req_gap--;
				end else begin
					mon_word = word_backlog.pop_front();
					req.op <= mon_word.op;
					req.map_byte <= mon_word.map_byte;
					req.start_block <= mon_word.start_block;
					req_busy = 1'b1;
				end
			end
			req.valid <= req_busy;
		end
	end

	// receiver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_taken = 1'b0;
			rsp_stall = 0;
		end else begin
			if (rsp_taken) begin
				rsp_taken = 1'b0;
				if ($urandom_range(0, 63) == 0)
					rsp_calm = !rsp_calm;
				rsp_stall = rsp_calm ? 0 : $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
			end else if (rsp_stall > 0) begin
				rsp_stall--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				mon_word.op = req.op;
				mon_word.map_byte = req.map_byte;
				mon_word.start_block = req.start_block;
				walk_word(LIVE, mon_word, mon_emit, mon_hop);
				if (mon_emit)
					hop_expect.push_back(mon_hop);
				req_taken = 1'b1;
				words_taken++;
			end
			if (rsp.valid && rsp.ready) begin
				rsp_taken = 1'b1;
				if (hop_expect.size() == 0) begin
					$error("unexpected result word, block 0x%0h", rsp.block_number);
					errors++;
				end else begin
					mon_hop = hop_expect.pop_front();
					check_field("block_number", mon_hop.block_number, rsp.block_number);
					check_field("byte_offset", mon_hop.byte_offset, rsp.byte_offset);
					check_field("is_last", mon_hop.is_last, rsp.is_last);
					check_field("status", mon_hop.status, rsp.status);
					hops_seen++;
					if (mon_hop.status)
						map_exits++;
					else if (mon_hop.is_last)
						chain_ends++;
				end
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		cfg.valid <= 1'b0;
		cfg.index <= CFG_DIR_BLOCKS;
		cfg.data <= '0;
		reset_ctx(SHADOW);
		reset_ctx(LIVE);
		@(posedge arst_n);

		write_reg(CFG_DIR_BLOCKS, 0);
		write_reg(CFG_MAP_ENTRIES, 7);
		push_word(OP_STEP, 8'h00, 12'h000);
		for (int i = 11; i >= 0; i--)
			push_word(OP_LOAD, SAMPLE_MAP[i*8 +: 8], 12'h000);
		push_word(OP_LOAD, 8'hFF, 12'hFFF);
		push_word(OP_START, 8'h00, 12'd1);
		push_word(OP_STEP, 8'hFF, 12'hFFF);
		push_word(OP_START, 8'h00, 12'd2);
		repeat (3) push_word(OP_STEP, 8'h00, 12'h000);
		push_word(OP_START, 8'h00, 12'd4);
		repeat (2) push_word(OP_STEP, 8'h00, 12'h000);
		push_word(OP_START, 8'h00, 12'hFFF);
		push_word(OP_STEP, 8'h00, 12'h000);
		push_word(OP_IDLE, 8'hFF, 12'hFFF);
		settle();

		run_phase(1, 300, 350, 1'b0);
		run_phase(0, 0, 60, 1'b0);
		run_phase(16'hFFFF, 4096, 500, 1'b1);
		run_phase(16'h5A5A, 64, 200, 1'b0);
		run_phase(16'hA5A5, 8191, 700, 1'b0);

		$display("%0d input words taken, %0d block hops checked, %0d map entries loaded",
			words_taken, hops_seen, fill_ptr[LIVE]);
		$display("%0d chains ended on a link, %0d left the map", chain_ends, map_exits);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
